/* src/uert_pkg.sv */
package uert_pkg;

	localparam int CAP_W   = 16;
	localparam int CNT_W   = 16;
	localparam int WIDTH_W = 32;
	localparam int DIST_W  = 27;
	localparam int LIM_W   = 16;
	localparam int LVL_W   = 2;
	localparam int IDX_W   = 1;

	// floor(width * 343 / 20000) is split as width = a * 20000 + b:
	//   a = floor(width / 20000), b = width - a * 20000
	//   distance = a * 343 + floor(b * 343 / 20000)
	// Each division by 20000 is a shift by 5 and a reciprocal multiply for 625.
	localparam int QUO_W   = 18;   // floor((2^32 - 1) / 20000) < 2^18
	localparam int REM_W   = 15;   // remainder below 20000
	localparam int PROD_W  = 23;   // b * 343 below 6860000
	localparam int FRAC_W  = 9;    // floor(b * 343 / 20000) at most 342
	localparam int DEN_SHIFT = 5;  // 20000 = 625 * 32

	localparam int RECIP_HI_W     = 28;
	localparam int RECIP_HI_SHIFT = 37;
	localparam logic [RECIP_HI_W-1:0] RECIP_HI = 28'd219902326; // ceil(2^37 / 625)

	localparam int RECIP_LO_W     = 19;
	localparam int RECIP_LO_SHIFT = 28;
	localparam logic [RECIP_LO_W-1:0] RECIP_LO = 19'd429497;    // ceil(2^28 / 625)

	localparam logic [14:0] SOUND_DEN = 15'd20000;
	localparam logic [8:0]  SOUND_NUM = 9'd343;

	localparam logic [DIST_W-1:0] CLOSEST_RESET = 27'd9999;
	localparam logic [LIM_W-1:0]  NEAR_RESET    = 16'd30;
	localparam logic [LIM_W-1:0]  FAR_RESET     = 16'd100;

	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_CAPTURE = 1'b1;

	localparam logic [IDX_W-1:0] CFG_NEAR = 1'b0;
	localparam logic [IDX_W-1:0] CFG_FAR  = 1'b1;

	typedef enum logic [LVL_W-1:0] {
		LVL_FAR  = 2'd0,
		LVL_PROX = 2'd1,
		LVL_HIGH = 2'd2,
		LVL_NONE = 2'd3
	} level_t;

	typedef struct packed {
		logic               valid;
		logic [WIDTH_W-1:0] width;
	} pulse_t;

	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] cm;
	} range_t;

endpackage

/* src/uert_if.sv */
interface uert_in_if;
	import uert_pkg::*;

	logic             valid;
	logic             ready;
	logic             kind;
	logic [CAP_W-1:0] capture_value;

	modport source (output valid, output kind, output capture_value, input ready);
	modport sink (input valid, input kind, input capture_value, output ready);
endinterface

interface uert_out_if;
	import uert_pkg::*;

	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance_cm;
	logic [DIST_W-1:0] closest_cm;
	logic [LVL_W-1:0]  alert_level;
	logic              level_changed;

	modport source (output valid, output distance_cm, output closest_cm,
		output alert_level, output level_changed, input ready);
	modport sink (input valid, input distance_cm, input closest_cm,
		input alert_level, input level_changed, output ready);
endinterface

/* src/uert_timing.sv */
module uert_timing (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   take,
	input  logic                   kind,
	input  logic [uert_pkg::CAP_W-1:0] capture_value,
	output uert_pkg::pulse_t       pulse_s1
);
	import uert_pkg::*;

	logic [CNT_W-1:0]   ovf_q;
	logic [CAP_W-1:0]   start_q;
	logic               await_q;
	logic [WIDTH_W-1:0] end_time;
	logic               falling;

	// overflow count forms the upper half of the end time
	assign end_time = {ovf_q, capture_value};
	assign falling  = take && (kind == KIND_CAPTURE) && await_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q   <= '0;
			start_q <= '0;
			await_q <= 1'b0;
		end else if (take) begin
			case (kind)
				KIND_TICK: begin
					ovf_q <= ovf_q + 1'b1;
				end
				KIND_CAPTURE: begin
					if (!await_q) begin
						ovf_q   <= '0;
						start_q <= capture_value;
						await_q <= 1'b1;
					end else begin
						await_q <= 1'b0;
					end
				end
				default: begin
					ovf_q <= ovf_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_s1 <= '0;
		end else if (en) begin
			pulse_s1.valid <= falling;
			pulse_s1.width <= end_time - {{(WIDTH_W-CAP_W){1'b0}}, start_q};
		end
	end
endmodule

/* src/uert_dist.sv */
module uert_dist (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  uert_pkg::pulse_t pulse_s1,
	output uert_pkg::range_t range_s5
);
	import uert_pkg::*;

	localparam int HI_IN_W  = WIDTH_W - DEN_SHIFT;
	localparam int HI_P_W   = HI_IN_W + RECIP_HI_W;
	localparam int LO_IN_W  = PROD_W - DEN_SHIFT;
	localparam int LO_P_W   = LO_IN_W + RECIP_LO_W;

	logic [2:0] valid_q;

	logic [QUO_W-1:0]   quo_s2;
	logic [WIDTH_W-1:0] wid_s2;
	logic [QUO_W-1:0]   quo_s3;
	logic [REM_W-1:0]   rem_s3;
	logic [DIST_W-1:0]  whole_s4;
	logic [PROD_W-1:0]  part_s4;

	logic [HI_P_W-1:0]  hi_prod;
	logic [WIDTH_W-1:0] back_prod;
	logic [WIDTH_W-1:0] rem_full;
	logic [DIST_W-1:0]  whole_full;
	logic [PROD_W-1:0]  part_full;
	logic [LO_P_W-1:0]  lo_prod;
	logic [FRAC_W-1:0]  frac;

	// quotient by 20000: shift out 32, then reciprocal multiply for 625
	assign hi_prod = HI_P_W'(pulse_s1.width[WIDTH_W-1:DEN_SHIFT]) * HI_P_W'(RECIP_HI);

	assign back_prod = WIDTH_W'(quo_s2) * WIDTH_W'(SOUND_DEN);
	assign rem_full  = wid_s2 - back_prod;

	assign whole_full = DIST_W'(quo_s3) * DIST_W'(SOUND_NUM);
	assign part_full  = PROD_W'(rem_s3) * PROD_W'(SOUND_NUM);

	assign lo_prod = LO_P_W'(part_s4[PROD_W-1:DEN_SHIFT]) * LO_P_W'(RECIP_LO);
	assign frac    = lo_prod[RECIP_LO_SHIFT +: FRAC_W];

	// valid walks alongside the data: s2, s3, s4, then s5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			range_s5 <= '0;
		end else if (en) begin
			valid_q        <= {valid_q[1:0], pulse_s1.valid};
			range_s5.valid <= valid_q[2];
			range_s5.cm    <= whole_s4 + DIST_W'(frac);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s2        <= hi_prod[RECIP_HI_SHIFT +: QUO_W];
			wid_s2        <= pulse_s1.width;
			quo_s3        <= quo_s2;
			rem_s3        <= rem_full[REM_W-1:0];
			whole_s4      <= whole_full;
			part_s4       <= part_full;
		end
	end
endmodule

/* src/uert_threat.sv */
module uert_threat (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          cfg_we,
	input  logic [uert_pkg::IDX_W-1:0]    cfg_index,
	input  logic [uert_pkg::LIM_W-1:0]    cfg_data,
	input  uert_pkg::range_t              range_s5,
	output logic                          out_valid,
	output logic [uert_pkg::DIST_W-1:0]   distance_cm,
	output logic [uert_pkg::DIST_W-1:0]   closest_cm,
	output logic [uert_pkg::LVL_W-1:0]    alert_level,
	output logic                          level_changed
);
	import uert_pkg::*;

	logic [LIM_W-1:0]  near_q;
	logic [LIM_W-1:0]  far_q;
	logic [DIST_W-1:0] closest_q;
	level_t            prev_q;
	logic [DIST_W-1:0] new_min;
	level_t            level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= NEAR_RESET;
			far_q  <= FAR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NEAR: near_q <= cfg_data;
				CFG_FAR:  far_q  <= cfg_data;
				default:  near_q <= near_q;
			endcase
		end
	end

	// never raise the minimum; the near test wins over the far test
	always_comb begin
		new_min = (range_s5.cm < closest_q) ? range_s5.cm : closest_q;
		if (new_min < DIST_W'(near_q)) begin
			level = LVL_HIGH;
		end else if (new_min <= DIST_W'(far_q)) begin
			level = LVL_PROX;
		end else begin
			level = LVL_FAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			closest_q <= CLOSEST_RESET;
			prev_q    <= LVL_NONE;
		end else if (en) begin
			out_valid <= range_s5.valid;
			if (range_s5.valid) begin
				closest_q <= new_min;
				prev_q    <= level;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && range_s5.valid) begin
			distance_cm   <= range_s5.cm;
			closest_cm    <= new_min;
			alert_level   <= LVL_W'(level);
			level_changed <= (level != prev_q);
		end
	end
endmodule

/* src/ultrasonic_echo_range_threat_top.sv */
// Channel  Role   Transfer carries
// -------  -----  ---------------------------------------------------------
// in_ch    sink   kind (tick / capture), capture_value
// out_ch   source distance_cm, closest_cm, alert_level, level_changed
// cfg      write  cfg_we, cfg_index (0 near limit, 1 far limit), cfg_data
//
// One timer event is taken every cycle while out_ch is not stalled. A falling
// capture passes six registers: the input stage forms the pulse width, four
// stages run the constant multiplies that turn it into centimetres, and the
// result register applies the running minimum and the threat classification.
// The result is offered on out_ch from the result register and leaves when
// out_ch.ready is high. Reset (arst_n low) clears the counters, the edge
// phase, the minimum (9999) and the limits (30, 100). While out_ch holds a
// result that is not taken, the whole pipeline and in_ch hold.
module ultrasonic_echo_range_threat_top (
	input  logic                       clk,
	input  logic                       arst_n,
	uert_in_if.sink                    in_ch,
	uert_out_if.source                 out_ch,
	input  logic                       cfg_we,
	input  logic [uert_pkg::IDX_W-1:0] cfg_index,
	input  logic [uert_pkg::LIM_W-1:0] cfg_data
);
	import uert_pkg::*;

	logic   en;
	logic   take;
	pulse_t pulse_s1;
	range_t range_s5;

	// advance everything unless a finished result is waiting at the output
	assign en          = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;
	assign take        = in_ch.valid && en;

	// edge pairing, overflow counting and pulse width
	uert_timing u_timing (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.take          (take),
		.kind          (in_ch.kind),
		.capture_value (in_ch.capture_value),
		.pulse_s1      (pulse_s1)
	);

	// width in microseconds to whole centimetres
	uert_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.pulse_s1 (pulse_s1),
		.range_s5 (range_s5)
	);

	// running minimum, limits, threat level and output register
	uert_threat u_threat (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.range_s5      (range_s5),
		.out_valid     (out_ch.valid),
		.distance_cm   (out_ch.distance_cm),
		.closest_cm    (out_ch.closest_cm),
		.alert_level   (out_ch.alert_level),
		.level_changed (out_ch.level_changed)
	);
endmodule
